### hw/rtl/display_pipe_allocator_assert.svh
// Assertion macros used by the display pipe allocator controller.
`ifndef DISPLAY_PIPE_ALLOCATOR_ASSERT_SVH
`define DISPLAY_PIPE_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define DPA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dpa assertion failed");

// Next-cycle implication, disabled while reset is low.
`define DPA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dpa assertion failed");

`endif

### hw/rtl/dpa_pkg.sv
// Package: types, codes and default sizes of the display pipe allocator.
`default_nettype none
package dpa_pkg;

    localparam int DPA_MAX_PIPES    = 16;
    localparam int DPA_NUM_DISPLAYS = 4;
    localparam int DPA_NUM_BLOCKS   = 32;
    localparam int OWNER_W          = 3;

    typedef enum logic [1:0] {
        ACT_CLEAR     = 2'd0,
        ACT_APPEND    = 2'd1,
        ACT_SEARCH    = 2'd2,
        ACT_END_ROUND = 2'd3
    } t_dpa_action;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN,
        ST_BACKUP,
        ST_DONE
    } t_dpa_state;

    typedef struct packed {
        t_dpa_action action;
        logic [31:0] pipe_number;
        logic [31:0] block_mask;
        logic        virt_pipe;
        logic        blocks_secure;
        logic        supports_yuv;
        logic [1:0]  display;
        logic        needs_vig;
        logic        secure_content;
        logic [4:0]  block_index;
    } t_dpa_in;

    typedef struct packed {
        logic [31:0] granted_pipe;
        logic        granted;
        logic        table_full;
    } t_dpa_out;

    typedef struct packed {
        logic load_item;
        logic exec;
        logic scan_step;
        logic grant_backup;
        logic load_out;
    } t_dpa_cmd;

    typedef struct packed {
        t_dpa_action action;
        logic        args_ok;
        logic        table_empty;
        logic        scan_last;
        logic        hit;
    } t_dpa_stat;

endpackage
`default_nettype wire

### hw/rtl/dpa_datapath.sv
// Datapath: pipe table, scan index, backup tracking and result registers.
`default_nettype none
module dpa_datapath #(
    parameter int MAX_PIPES    = dpa_pkg::DPA_MAX_PIPES,
    parameter int NUM_DISPLAYS = dpa_pkg::DPA_NUM_DISPLAYS,
    parameter int NUM_BLOCKS   = dpa_pkg::DPA_NUM_BLOCKS
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire dpa_pkg::t_dpa_cmd i_cmd,
    output dpa_pkg::t_dpa_stat     o_stat,
    input  wire dpa_pkg::t_dpa_in  i_item,
    output dpa_pkg::t_dpa_out      o_out_item
);
    import dpa_pkg::*;

    localparam int IW = (MAX_PIPES > 1) ? $clog2(MAX_PIPES) : 1;
    localparam int CW = $clog2(MAX_PIPES + 1);
    localparam logic [OWNER_W-1:0] UNOWNED    = OWNER_W'(NUM_DISPLAYS);
    localparam logic [CW-1:0]      FULL_COUNT = CW'(MAX_PIPES);
    localparam logic [5:0]         BLK_LIMIT  = 6'(NUM_BLOCKS);

    logic [31:0]        r_pipe  [MAX_PIPES];
    logic [31:0]        r_mask  [MAX_PIPES];
    logic [2:0]         r_flags [MAX_PIPES];
    logic [OWNER_W-1:0] r_cur   [MAX_PIPES];
    logic [OWNER_W-1:0] r_prev  [MAX_PIPES];

    logic [CW-1:0] r_count;
    t_dpa_in       r_item;
    logic [IW-1:0] r_idx;
    logic          r_bk_have;
    logic [IW-1:0] r_bk_idx;
    logic [31:0]   r_bk_pipe;
    logic [31:0]   r_res_pipe;
    logic          r_res_granted;
    logic          r_res_full;
    t_dpa_out      r_out;

    logic [31:0]        w_e_pipe;
    logic [31:0]        w_e_mask;
    logic [2:0]         w_e_flags;
    logic [OWNER_W-1:0] w_e_cur;
    logic [OWNER_W-1:0] w_e_prev;
    logic [OWNER_W-1:0] w_disp;
    logic               w_disp_ok;
    logic               w_blk_ok;
    logic               w_elig;
    logic               w_hit;
    logic               w_backup;
    logic               w_round_sel;
    logic               w_full;
    logic [IW-1:0]      w_wr_idx;

    assign w_e_pipe  = r_pipe[r_idx];
    assign w_e_mask  = r_mask[r_idx];
    assign w_e_flags = r_flags[r_idx];
    assign w_e_cur   = r_cur[r_idx];
    assign w_e_prev  = r_prev[r_idx];

    assign w_disp    = OWNER_W'(r_item.display);
    assign w_disp_ok = w_disp < UNOWNED;
    assign w_blk_ok  = {1'b0, r_item.block_index} < BLK_LIMIT;
    assign w_full    = r_count == FULL_COUNT;
    assign w_wr_idx  = r_count[IW-1:0];

    // flags: bit 0 virtual, bit 1 blocks secure, bit 2 YUV
    assign w_elig = w_e_mask[r_item.block_index] && !w_e_flags[0]
                 && !(w_e_flags[1] && r_item.secure_content)
                 && (w_e_cur == UNOWNED)
                 && ((w_e_prev == UNOWNED) || (w_e_prev == w_disp));
    assign w_hit       = w_elig && (r_item.needs_vig == w_e_flags[2]);
    assign w_backup    = w_elig && !r_item.needs_vig && w_e_flags[2];
    assign w_round_sel = (w_e_prev == w_disp) || (w_e_prev == UNOWNED);

    always_comb begin
        o_stat.action      = r_item.action;
        o_stat.args_ok     = w_disp_ok && ((r_item.action != ACT_SEARCH) || w_blk_ok);
        o_stat.table_empty = r_count == '0;
        o_stat.scan_last   = (CW'(r_idx) + CW'(1)) == r_count;
        o_stat.hit         = w_hit;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.exec) begin
            case (r_item.action)
                ACT_CLEAR: r_count <= '0;
                ACT_APPEND: begin
                    if (!w_full) begin
                        r_count <= r_count + CW'(1);
                    end
                end
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_item        <= i_item;
            r_res_pipe    <= '0;
            r_res_granted <= 1'b0;
            r_res_full    <= 1'b0;
        end
        if (i_cmd.exec) begin
            case (r_item.action)
                ACT_APPEND: begin
                    if (w_full) begin
                        r_res_full <= 1'b1;
                    end else begin
                        r_pipe[w_wr_idx]  <= r_item.pipe_number;
                        r_mask[w_wr_idx]  <= r_item.block_mask;
                        r_flags[w_wr_idx] <= {r_item.supports_yuv, r_item.blocks_secure,
                                              r_item.virt_pipe};
                        r_cur[w_wr_idx]   <= UNOWNED;
                        r_prev[w_wr_idx]  <= UNOWNED;
                    end
                end
                ACT_SEARCH, ACT_END_ROUND: begin
                    r_idx     <= '0;
                    r_bk_have <= 1'b0;
                end
                default: r_idx <= r_idx;
            endcase
        end
        if (i_cmd.scan_step) begin
            if (r_item.action == ACT_SEARCH) begin
                if (w_hit) begin
                    r_cur[r_idx]  <= w_disp;
                    r_res_pipe    <= w_e_pipe;
                    r_res_granted <= 1'b1;
                end else if (w_backup) begin
                    r_bk_have <= 1'b1;
                    r_bk_idx  <= r_idx;
                    r_bk_pipe <= w_e_pipe;
                end
            end else if (w_round_sel) begin
                r_prev[r_idx] <= w_e_cur;
                r_cur[r_idx]  <= UNOWNED;
            end
            r_idx <= r_idx + IW'(1);
        end
        if (i_cmd.grant_backup && r_bk_have) begin
            r_cur[r_bk_idx] <= w_disp;
            r_res_pipe      <= r_bk_pipe;
            r_res_granted   <= 1'b1;
        end
        if (i_cmd.load_out) begin
            r_out.granted_pipe <= r_res_pipe;
            r_out.granted      <= r_res_granted;
            r_out.table_full   <= r_res_full;
        end
    end

    assign o_out_item = r_out;

endmodule
`default_nettype wire

### hw/rtl/dpa_ctrl.sv
// Controller: sequences each item through execute, table scan and result hand-off.
`default_nettype none
module dpa_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    input  wire dpa_pkg::t_dpa_stat i_stat,
    output dpa_pkg::t_dpa_cmd       o_cmd
);
    import dpa_pkg::*;

    `include "display_pipe_allocator_assert.svh"

    t_dpa_state r_state;
    t_dpa_state n_state;
    logic       r_out_valid;
    logic       n_out_valid;
    logic       w_slot_free;
    logic       w_scan_op;

    assign w_slot_free = !r_out_valid || !i_out_stall;
    assign w_scan_op   = (i_stat.action == ACT_SEARCH) || (i_stat.action == ACT_END_ROUND);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_item = 1'b1;
                    n_state         = ST_EXEC;
                end
            end
            ST_EXEC: begin
                o_cmd.exec = 1'b1;
                if (w_scan_op && i_stat.args_ok && !i_stat.table_empty) begin
                    n_state = ST_SCAN;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if ((i_stat.action == ACT_SEARCH) && i_stat.hit) begin
                    n_state = ST_DONE;
                end else if (i_stat.scan_last) begin
                    n_state = (i_stat.action == ACT_SEARCH) ? ST_BACKUP : ST_DONE;
                end
            end
            ST_BACKUP: begin
                o_cmd.grant_backup = 1'b1;
                n_state            = ST_DONE;
            end
            ST_DONE: begin
                if (w_slot_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_in_stall  = r_state != ST_IDLE;
    assign o_out_valid = r_out_valid;

    `DPA_ASSERT_NEXT(a_accept_to_exec, i_clk, i_rst_n, i_in_valid && !o_in_stall,
        r_state == ST_EXEC)
    `DPA_ASSERT_NOW(a_load_out_free, i_clk, i_rst_n, o_cmd.load_out,
        !r_out_valid || !i_out_stall)
    `DPA_ASSERT_NOW(a_scan_nonempty, i_clk, i_rst_n, r_state == ST_SCAN,
        !i_stat.table_empty && w_scan_op)
    `DPA_ASSERT_NEXT(a_done_after_hit, i_clk, i_rst_n,
        r_state == ST_SCAN && i_stat.action == ACT_SEARCH && i_stat.hit,
        r_state == ST_DONE)

endmodule
`default_nettype wire

### hw/rtl/display_pipe_allocator.sv
// Top level of the display pipe allocator: controller plus table datapath.
//
// Input channel i_in_valid / o_in_stall carries one item (clear, append, search
// or end of round) in i_in_item. Output channel o_out_valid / i_out_stall gives
// exactly one result item per input item in o_out_item, in order.
// One item is worked on at a time. Clear and append pass from accept through
// the execute and done states to the result; search and end of round walk
// the table one entry per cycle between those states (a search stops at its
// first direct match; a search with no direct match then passes through a
// fallback grant state). The scan of the entry table uses a single read port.
// The next item is accepted as soon as the previous one has been moved into
// the output register, even while that result is still waiting.
// A stalled receiver holds the result in the output register; the block then
// finishes at most one more item and waits with o_in_stall high.
// Reset clears the entry count and all control state; the table itself is
// not cleared and entries are only read once appended.
`default_nettype none
module display_pipe_allocator #(
    parameter int MAX_PIPES    = dpa_pkg::DPA_MAX_PIPES,
    parameter int NUM_DISPLAYS = dpa_pkg::DPA_NUM_DISPLAYS,
    parameter int NUM_BLOCKS   = dpa_pkg::DPA_NUM_BLOCKS
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_stall,
    input  wire dpa_pkg::t_dpa_in i_in_item,
    output logic                  o_out_valid,
    input  wire logic             i_out_stall,
    output dpa_pkg::t_dpa_out     o_out_item
);
    import dpa_pkg::*;

    t_dpa_cmd  w_cmd;
    t_dpa_stat w_stat;

    dpa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    dpa_datapath #(
        .MAX_PIPES    (MAX_PIPES),
        .NUM_DISPLAYS (NUM_DISPLAYS),
        .NUM_BLOCKS   (NUM_BLOCKS)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .o_stat     (w_stat),
        .i_item     (i_in_item),
        .o_out_item (o_out_item)
    );

endmodule
`default_nettype wire
